/* hdl/irpd_pkg.sv */
// ----------------------------------------------------------------------------
// irpd_pkg
// Shared types, constants and window checks for the IR pulse distance decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package irpd_pkg;

    localparam int TICK_W  = 16;
    localparam int BOUND_W = TICK_W + 1;
    localparam int IDX_W   = 7;
    localparam int WORD_W  = 32;
    localparam int CFG_IDX_W = 3;

    // Frame layout in durations.
    localparam logic [IDX_W-1:0] FRAME_LEN  = 7'd67;
    localparam logic [IDX_W-1:0] FIRST_DATA = 7'd3;
    localparam logic [IDX_W-1:0] INDEX_MAX  = 7'd127;

    // Nominal timings after reset, in capture ticks.
    localparam int RST_LEAD_MARK  = 9000;
    localparam int RST_LEAD_SPACE = 4500;
    localparam int RST_BIT_MARK   = 560;
    localparam int RST_ONE_SPACE  = 1690;
    localparam int RST_ZERO_SPACE = 560;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LEAD_MARK  = 3'd0,
        REG_LEAD_SPACE = 3'd1,
        REG_BIT_MARK   = 3'd2,
        REG_ONE_SPACE  = 3'd3,
        REG_ZERO_SPACE = 3'd4
    } cfg_reg_t;

    localparam logic [CFG_IDX_W-1:0] NUM_REGS = 3'd5;

    // One tolerance window: nominal minus and plus the tolerance.
    typedef struct packed {
        logic [TICK_W-1:0]  lo;
        logic [BOUND_W-1:0] hi;
    } window_t;

    typedef struct packed {
        window_t lead_mark;
        window_t lead_space;
        window_t bit_mark;
        window_t one_space;
        window_t zero_space;
    } windows_t;

    function automatic logic in_closed(input logic [TICK_W-1:0] x, input window_t w);
        in_closed = (x >= w.lo) && ({1'b0, x} <= w.hi);
    endfunction

    function automatic logic in_open(input logic [TICK_W-1:0] x, input window_t w);
        in_open = (x > w.lo) && ({1'b0, x} < w.hi);
    endfunction

endpackage

`default_nettype wire

/* hdl/ir_pulse_distance_decoder.sv */
// ----------------------------------------------------------------------------
// ir_pulse_distance_decoder
// 32-bit pulse distance IR frame decoder fed with captured durations.
// ----------------------------------------------------------------------------
// Each request on the s_ channel carries one captured duration, alternating
// mark and space from the lead mark on. The lead mark and lead space are
// checked against windows of nominal plus or minus nominal/TOL_DIV, the third
// duration is skipped, then each space is decoded as a one or a zero (LSB
// first) and each mark is checked. The duration flagged with s_last_pulse
// produces one request on the m_ channel: m_frame_ok is high only when exactly
// 67 durations arrived and every window passed, and m_decoded_word is zero on
// a failed frame. The decoder then rearms for the next frame. A duration
// passes through the input register, then the decode logic into the frame
// state and the result register. A new duration is accepted every cycle
// unless a held result blocks the next last duration or a configuration
// write to a listed register holds s_ready low while the reciprocal
// multiplier turns the nominal into a window.
// ----------------------------------------------------------------------------
`default_nettype none

module ir_pulse_distance_decoder #(
    parameter int TOL_DIV = 4
) (
    input  wire                                  aclk,
    input  wire                                  aresetn,
    input  wire                                  s_valid,
    output logic                                 s_ready,
    input  wire  [irpd_pkg::TICK_W-1:0]          s_pulse_ticks,
    input  wire                                  s_last_pulse,
    output logic                                 m_valid,
    input  wire                                  m_ready,
    output logic                                 m_frame_ok,
    output logic [irpd_pkg::WORD_W-1:0]          m_decoded_word,
    input  wire                                  cfg_valid,
    output logic                                 cfg_ready,
    input  wire  [irpd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire  [irpd_pkg::TICK_W-1:0]          cfg_data
);
    import irpd_pkg::*;

    windows_t          windows;
    logic              cfg_busy;

    // Input register.
    logic              in_valid_reg;
    logic [TICK_W-1:0] in_ticks_reg;
    logic              in_last_reg;

    // Frame state.
    logic [IDX_W-1:0]  pulse_index_reg;
    logic [IDX_W-1:0]  pulse_index_next;
    logic              timing_error_reg;
    logic              timing_error_next;
    logic [WORD_W-1:0] bit_acc_reg;
    logic [WORD_W-1:0] bit_acc_next;

    // Result register.
    logic              m_valid_reg;
    logic              m_frame_ok_reg;
    logic [WORD_W-1:0] m_decoded_word_reg;

    logic              advance;
    logic              in_data;
    logic [IDX_W-1:0]  data_off;
    logic [4:0]        bit_pos;
    logic              frame_ok;

    assign cfg_ready = 1'b1;

    irpd_cfg #(
        .TOL_DIV (TOL_DIV)
    ) u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .windows  (windows),
        .busy     (cfg_busy)
    );

    // The held duration moves on unless it would produce a result while the
    // previous result is still waiting.
    assign advance = in_valid_reg && (!in_last_reg || !m_valid_reg || m_ready);
    assign s_ready = (!in_valid_reg || advance) && !cfg_busy;

    assign in_data  = (pulse_index_reg >= FIRST_DATA) && (pulse_index_reg < FRAME_LEN);
    assign data_off = pulse_index_reg - FIRST_DATA;
    assign bit_pos  = data_off[5:1];

    always_comb begin
        timing_error_next = timing_error_reg;
        bit_acc_next      = bit_acc_reg;
        priority if (pulse_index_reg == '0) begin
            if (!in_closed(in_ticks_reg, windows.lead_mark)) timing_error_next = 1'b1;
        end else if (pulse_index_reg == IDX_W'(1)) begin
            if (!in_closed(in_ticks_reg, windows.lead_space)) timing_error_next = 1'b1;
        end else if (in_data && pulse_index_reg[0]) begin
            // Spaces: the one window wins where the two windows overlap.
            if (in_open(in_ticks_reg, windows.one_space)) begin
                bit_acc_next[bit_pos] = 1'b1;
            end else if (!in_open(in_ticks_reg, windows.zero_space)) begin
                timing_error_next = 1'b1;
            end
        end else if (in_data) begin
            if (!in_closed(in_ticks_reg, windows.bit_mark)) timing_error_next = 1'b1;
        end else begin
            // The skipped third duration and anything past the frame end.
        end
        pulse_index_next = (pulse_index_reg == INDEX_MAX) ? pulse_index_reg
                                                          : pulse_index_reg + IDX_W'(1);
    end

    assign frame_ok = (pulse_index_next == FRAME_LEN) && !timing_error_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg     <= 1'b0;
            pulse_index_reg  <= '0;
            timing_error_reg <= 1'b0;
            bit_acc_reg      <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end

            if (advance) begin
                if (in_last_reg) begin
                    pulse_index_reg  <= '0;
                    timing_error_reg <= 1'b0;
                    bit_acc_reg      <= '0;
                end else begin
                    pulse_index_reg  <= pulse_index_next;
                    timing_error_reg <= timing_error_next;
                    bit_acc_reg      <= bit_acc_next;
                end
            end

            if (advance && in_last_reg) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end

        if (s_valid && s_ready) begin
            in_ticks_reg <= s_pulse_ticks;
            in_last_reg  <= s_last_pulse;
        end
        if (advance && in_last_reg) begin
            m_frame_ok_reg     <= frame_ok;
            m_decoded_word_reg <= frame_ok ? bit_acc_next : '0;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_frame_ok     = m_frame_ok_reg;
    assign m_decoded_word = m_decoded_word_reg;

`ifndef ASSERT_OFF
    // A failed frame never shows partially decoded bits.
    a_fail_word_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_frame_ok |-> m_decoded_word == '0)
        else $error("failed frame carries a nonzero word");

    // Closing a frame rearms the decoder.
    a_rearm: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_last_reg |=> pulse_index_reg == '0 && !timing_error_reg
                                   && bit_acc_reg == '0)
        else $error("frame state not cleared after a result");

    // No duration is taken while a window is being rebuilt.
    a_cfg_block: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_busy |-> !s_ready)
        else $error("input accepted during a window update");

    // A waiting result is never overwritten by a new one.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_ready |-> !(advance && in_last_reg))
        else $error("result overwritten while stalled");
`endif

endmodule

`default_nettype wire

/* hdl/irpd_cfg.sv */
// ----------------------------------------------------------------------------
// irpd_cfg
// Timing registers; turns each written nominal into a tolerance window.
// ----------------------------------------------------------------------------
`default_nettype none

module irpd_cfg #(
    parameter int TOL_DIV = 4
) (
    input  wire                                  aclk,
    input  wire                                  aresetn,
    input  wire                                  wr_en,
    input  wire  [irpd_pkg::CFG_IDX_W-1:0]       wr_index,
    input  wire  [irpd_pkg::TICK_W-1:0]          wr_data,
    output irpd_pkg::windows_t                   windows,
    output logic                                 busy
);
    import irpd_pkg::*;

    // nom / TOL_DIV as a multiply by a rounded-up reciprocal; exact for 16-bit values.
    localparam int SHIFT   = TICK_W + $clog2(TOL_DIV);
    localparam int RECIP_I = ((1 << SHIFT) + TOL_DIV - 1) / TOL_DIV;
    localparam logic [BOUND_W-1:0] RECIP = BOUND_W'(RECIP_I);
    localparam int PROD_W = TICK_W + BOUND_W;

    localparam window_t RST_LM = '{lo: TICK_W'(RST_LEAD_MARK - RST_LEAD_MARK / TOL_DIV),
                                   hi: BOUND_W'(RST_LEAD_MARK + RST_LEAD_MARK / TOL_DIV)};
    localparam window_t RST_LS = '{lo: TICK_W'(RST_LEAD_SPACE - RST_LEAD_SPACE / TOL_DIV),
                                   hi: BOUND_W'(RST_LEAD_SPACE + RST_LEAD_SPACE / TOL_DIV)};
    localparam window_t RST_BM = '{lo: TICK_W'(RST_BIT_MARK - RST_BIT_MARK / TOL_DIV),
                                   hi: BOUND_W'(RST_BIT_MARK + RST_BIT_MARK / TOL_DIV)};
    localparam window_t RST_OS = '{lo: TICK_W'(RST_ONE_SPACE - RST_ONE_SPACE / TOL_DIV),
                                   hi: BOUND_W'(RST_ONE_SPACE + RST_ONE_SPACE / TOL_DIV)};
    localparam window_t RST_ZS = '{lo: TICK_W'(RST_ZERO_SPACE - RST_ZERO_SPACE / TOL_DIV),
                                   hi: BOUND_W'(RST_ZERO_SPACE + RST_ZERO_SPACE / TOL_DIV)};

    logic                 a_valid_reg;
    logic [CFG_IDX_W-1:0] a_index_reg;
    logic [TICK_W-1:0]    a_nom_reg;
    logic                 b_valid_reg;
    logic [CFG_IDX_W-1:0] b_index_reg;
    logic [TICK_W-1:0]    b_nom_reg;
    logic [TICK_W-1:0]    b_delta_reg;
    logic [PROD_W-1:0]    prod;
    window_t              new_window;
    windows_t             windows_reg;

    assign prod = {{BOUND_W{1'b0}}, a_nom_reg} * {{TICK_W{1'b0}}, RECIP};
    assign new_window.lo = b_nom_reg - b_delta_reg;
    assign new_window.hi = {1'b0, b_nom_reg} + {1'b0, b_delta_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            windows_reg <= '{lead_mark: RST_LM, lead_space: RST_LS, bit_mark: RST_BM,
                             one_space: RST_OS, zero_space: RST_ZS};
        end else begin
            // Writes to indexes past the register list are dropped here.
            a_valid_reg <= wr_en && (wr_index < NUM_REGS);
            b_valid_reg <= a_valid_reg;
            if (b_valid_reg) begin
                unique case (b_index_reg)
                    REG_LEAD_MARK:  windows_reg.lead_mark  <= new_window;
                    REG_LEAD_SPACE: windows_reg.lead_space <= new_window;
                    REG_BIT_MARK:   windows_reg.bit_mark   <= new_window;
                    REG_ONE_SPACE:  windows_reg.one_space  <= new_window;
                    REG_ZERO_SPACE: windows_reg.zero_space <= new_window;
                    default: ;
                endcase
            end
        end
        a_index_reg <= wr_index;
        a_nom_reg   <= wr_data;
        b_index_reg <= a_index_reg;
        b_nom_reg   <= a_nom_reg;
        b_delta_reg <= TICK_W'(prod >> SHIFT);
    end

    assign windows = windows_reg;
    assign busy    = a_valid_reg || b_valid_reg;

endmodule

`default_nettype wire

/* tb/irpd_frame_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// irpd_frame_checker
// Watches the decoder's channels, predicts each frame result and compares.
// ----------------------------------------------------------------------------
module irpd_frame_checker #(
    parameter int TOL_DIV = 4
) (
    input  wire                             aclk,
    input  wire                             aresetn,
    input  wire                             s_valid,
    input  wire                             s_ready,
    input  wire  [irpd_pkg::TICK_W-1:0]     s_pulse_ticks,
    input  wire                             s_last_pulse,
    input  wire                             m_valid,
    input  wire                             m_ready,
    input  wire                             m_frame_ok,
    input  wire  [irpd_pkg::WORD_W-1:0]     m_decoded_word,
    input  wire                             cfg_valid,
    input  wire                             cfg_ready,
    input  wire  [irpd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire  [irpd_pkg::TICK_W-1:0]     cfg_data,
    output int unsigned                     fail_count,
    output int unsigned                     frames_pending
);
    import irpd_pkg::*;

    typedef struct packed {
        logic              ok;
        logic [WORD_W-1:0] word;
    } frame_result_t;

    frame_result_t     frames_due[$];
    logic [TICK_W-1:0] nominal [NUM_REGS];
    logic [IDX_W-1:0]  pos_count;
    logic              frame_bad;
    logic [WORD_W-1:0] frame_bits;
    int unsigned       errors;

    function automatic bit window_hit(input logic [TICK_W-1:0] x,
                                      input logic [TICK_W-1:0] nom, input bit closed);
        int tol, lo, hi;
        tol = int'(nom) / TOL_DIV;
        lo  = int'(nom) - tol;
        hi  = int'(nom) + tol;
        if (closed) begin
            return int'(x) >= lo && int'(x) <= hi;
        end
        return int'(x) > lo && int'(x) < hi;
    endfunction

    task automatic decode_duration(input logic [TICK_W-1:0] ticks, input logic last);
        frame_result_t res;
        int unsigned   bit_pos;
        if (pos_count == 0) begin
            if (!window_hit(ticks, nominal[REG_LEAD_MARK], 1'b1)) frame_bad = 1'b1;
        end else if (pos_count == 1) begin
            if (!window_hit(ticks, nominal[REG_LEAD_SPACE], 1'b1)) frame_bad = 1'b1;
        end else if (pos_count >= FIRST_DATA && pos_count < FRAME_LEN) begin
            if (pos_count[0]) begin
                // The one window wins where the two space windows overlap.
                bit_pos = (pos_count - FIRST_DATA) >> 1;
                if (window_hit(ticks, nominal[REG_ONE_SPACE], 1'b0)) begin
                    frame_bits[bit_pos] = 1'b1;
                end else if (!window_hit(ticks, nominal[REG_ZERO_SPACE], 1'b0)) begin
                    frame_bad = 1'b1;
                end
            end else if (!window_hit(ticks, nominal[REG_BIT_MARK], 1'b1)) begin
                frame_bad = 1'b1;
            end
        end
        if (pos_count != INDEX_MAX) pos_count++;
        if (last) begin
            res.ok   = (pos_count == FRAME_LEN) && !frame_bad;
            res.word = res.ok ? frame_bits : '0;
            frames_due.push_back(res);
            pos_count  = '0;
            frame_bad  = 1'b0;
            frame_bits = '0;
        end
    endtask

    always @(posedge aclk) begin
        frame_result_t due;
        if (!aresetn) begin
            nominal[REG_LEAD_MARK]  = RST_LEAD_MARK;
            nominal[REG_LEAD_SPACE] = RST_LEAD_SPACE;
            nominal[REG_BIT_MARK]   = RST_BIT_MARK;
            nominal[REG_ONE_SPACE]  = RST_ONE_SPACE;
            nominal[REG_ZERO_SPACE] = RST_ZERO_SPACE;
            pos_count  = '0;
            frame_bad  = 1'b0;
            frame_bits = '0;
            frames_due.delete();
            errors = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (frames_due.size() == 0) begin
                    $display("%0t: unexpected result: expected none, actual ok=%0b word=%h",
                             $time, m_frame_ok, m_decoded_word);
                    errors++;
                end else begin
                    due = frames_due.pop_front();
                    if (m_frame_ok !== due.ok) begin
                        $display("%0t: frame_ok: expected %0b, actual %0b",
                                 $time, due.ok, m_frame_ok);
                        errors++;
                    end
                    if (m_decoded_word !== due.word) begin
                        $display("%0t: decoded_word: expected %h, actual %h",
                                 $time, due.word, m_decoded_word);
                        errors++;
                    end
                end
            end
            if (cfg_valid && cfg_ready && cfg_index < NUM_REGS) nominal[cfg_index] = cfg_data;
            if (s_valid && s_ready) decode_duration(s_pulse_ticks, s_last_pulse);
        end
        fail_count     <= errors;
        frames_pending <= frames_due.size();
    end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the IR pulse distance decoder.
// ----------------------------------------------------------------------------
// A few hand-picked durations open the run. After that, five phases of random
// traffic follow, each under its own set of nominal timings: the values after
// reset, random plausible timings, timings at the ends of the 16-bit range,
// overlapping one and zero space windows, and the reset values again. Most
// traffic is well-formed 67-duration frames with random bits and durations
// anywhere inside their windows, bounds included. The rest is frames with one
// duration outside its window, frames of the wrong length, frames long enough
// to saturate the duration count, and short bursts of noise. The checker
// beside the decoder predicts every frame result and counts mismatches.
// ----------------------------------------------------------------------------
module tb_top;
    import irpd_pkg::*;

    localparam int          TOL_DIV       = 4;
    localparam int          TICK_MAX      = (1 << TICK_W) - 1;
    localparam int unsigned NO_FAULT      = 1000;
    localparam int unsigned PHASE_PULSES  = 180;
    localparam int unsigned PHASE_FRAMES  = 3;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned CYCLE_LIMIT   = 600000;

    logic                  aclk           = 1'b0;
    logic                  aresetn        = 1'b0;
    logic                  s_valid        = 1'b0;
    logic                  s_ready;
    logic [TICK_W-1:0]     s_pulse_ticks  = '0;
    logic                  s_last_pulse   = 1'b0;
    logic                  m_valid;
    logic                  m_ready        = 1'b0;
    logic                  m_frame_ok;
    logic [WORD_W-1:0]     m_decoded_word;
    logic                  cfg_valid      = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index      = '0;
    logic [TICK_W-1:0]     cfg_data       = '0;

    int unsigned           fail_count;
    int unsigned           frames_pending;
    int unsigned           cycle_count    = 0;
    int unsigned           pulses_sent    = 0;
    int unsigned           frames_sent    = 0;
    int unsigned           ready_left     = 0;
    bit                    idle_enable    = 1'b1;

    // Current nominal timings, kept only to aim the generated durations.
    logic [TICK_W-1:0]     stim_nominal [NUM_REGS];

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    ir_pulse_distance_decoder #(
        .TOL_DIV (TOL_DIV)
    ) u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_pulse_ticks  (s_pulse_ticks),
        .s_last_pulse   (s_last_pulse),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_frame_ok     (m_frame_ok),
        .m_decoded_word (m_decoded_word),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    irpd_frame_checker #(
        .TOL_DIV (TOL_DIV)
    ) u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_pulse_ticks  (s_pulse_ticks),
        .s_last_pulse   (s_last_pulse),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_frame_ok     (m_frame_ok),
        .m_decoded_word (m_decoded_word),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .fail_count     (fail_count),
        .frames_pending (frames_pending)
    );

    // The result side alternates between ready stretches and stall bursts.
    // Once idling is switched off it simply stays ready.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready    <= 1'b0;
            ready_left <= 0;
        end else if (ready_left != 0) begin
            ready_left <= ready_left - 1;
        end else if (idle_enable && $urandom_range(0, 3) == 0) begin
            m_ready    <= 1'b0;
            ready_left <= $urandom_range(0, 18);
        end else begin
            m_ready    <= 1'b1;
            ready_left <= $urandom_range(0, 30);
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    // Picks a duration inside the window of a nominal (hit) or outside it,
    // often right on a bound or one tick beyond it. An empty open window
    // leaves nothing to hit, so the nominal itself is returned.
    function automatic logic [TICK_W-1:0] pick_duration(input logic [TICK_W-1:0] nom,
                                                        input bit closed, input bit hit);
        int tol, lo, hi;
        tol = int'(nom) / TOL_DIV;
        lo  = int'(nom) - tol;
        hi  = int'(nom) + tol;
        if (!closed) begin
            lo++;
            hi--;
        end
        if (hi > TICK_MAX) hi = TICK_MAX;
        if (hit) begin
            if (lo > hi) return nom;
            case ($urandom_range(0, 3))
                0: return TICK_W'(lo);
                1: return TICK_W'(hi);
                default: return TICK_W'($urandom_range(lo, hi));
            endcase
        end
        if (lo > hi) return TICK_W'($urandom_range(0, TICK_MAX));
        if (hi < TICK_MAX && (lo == 0 || $urandom_range(0, 1) == 1)) begin
            return $urandom_range(0, 1) ? TICK_W'(hi + 1)
                                        : TICK_W'($urandom_range(hi + 1, TICK_MAX));
        end
        return $urandom_range(0, 1) ? TICK_W'(lo - 1) : TICK_W'($urandom_range(0, lo - 1));
    endfunction

    // One request on the duration channel. Valid is only dropped for an idle
    // burst; otherwise it stays high from one request to the next.
    task automatic send_pulse(input logic [TICK_W-1:0] ticks, input logic last);
        if (idle_enable && $urandom_range(0, 9) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_pulse_ticks <= ticks;
        s_last_pulse  <= last;
        do @(posedge aclk); while (!s_ready);
        pulses_sent++;
    endtask

    // A frame of len durations laid out as the decoder expects. The duration
    // at fault_at misses its window; durations past the frame length and the
    // ignored third one are arbitrary.
    task automatic send_frame(input int unsigned len, input int unsigned fault_at);
        logic [TICK_W-1:0] ticks;
        bit                hit;
        for (int unsigned i = 0; i < len; i++) begin
            hit = (i != fault_at);
            if (i == 0) begin
                ticks = pick_duration(stim_nominal[REG_LEAD_MARK], 1'b1, hit);
            end else if (i == 1) begin
                ticks = pick_duration(stim_nominal[REG_LEAD_SPACE], 1'b1, hit);
            end else if (i == 2 || i >= FRAME_LEN) begin
                ticks = TICK_W'($urandom_range(0, TICK_MAX));
            end else if (i % 2 == 1) begin
                if ($urandom_range(0, 1) == 1) begin
                    ticks = pick_duration(stim_nominal[REG_ONE_SPACE], 1'b0, hit);
                end else begin
                    ticks = pick_duration(stim_nominal[REG_ZERO_SPACE], 1'b0, hit);
                end
            end else begin
                ticks = pick_duration(stim_nominal[REG_BIT_MARK], 1'b1, hit);
            end
            send_pulse(ticks, i == len - 1);
        end
        frames_sent++;
    endtask

    // A short run of arbitrary durations. Sometimes it stops without the last
    // flag, so that it spills into the frame that follows.
    task automatic send_noise();
        int unsigned       count;
        bit                closes;
        logic [TICK_W-1:0] ticks;
        count  = $urandom_range(1, 8);
        closes = ($urandom_range(0, 3) != 0);
        for (int unsigned i = 0; i < count; i++) begin
            if ($urandom_range(0, 3) == 0) begin
                ticks = $urandom_range(0, 1) ? TICK_W'(TICK_MAX) : '0;
            end else begin
                ticks = TICK_W'($urandom_range(0, TICK_MAX));
            end
            send_pulse(ticks, closes && i == count - 1);
        end
        if (closes) frames_sent++;
    endtask

    task automatic send_random_sequence();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            send_frame(FRAME_LEN, NO_FAULT);
        end else if (pick < 60) begin
            send_frame(FRAME_LEN, $urandom_range(0, FRAME_LEN - 1));
        end else if (pick < 72) begin
            send_frame($urandom_range(60, 75), NO_FAULT);
        end else if (pick < 77) begin
            // Long enough to saturate the duration count.
            send_frame($urandom_range(120, 140), NO_FAULT);
        end else begin
            send_noise();
        end
    endtask

    // Random traffic for one phase, then a wait until every frame result has
    // come back and any trailing duration has worked its way through.
    task automatic run_traffic();
        int unsigned pulses_at_start, frames_at_start;
        pulses_at_start = pulses_sent;
        frames_at_start = frames_sent;
        while (pulses_sent - pulses_at_start < PHASE_PULSES ||
               frames_sent - frames_at_start < PHASE_FRAMES) begin
            send_random_sequence();
        end
        s_valid <= 1'b0;
        @(posedge aclk);
        while (frames_pending != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Register writes go back to back, valid held high across them.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TICK_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        if (idx < NUM_REGS) stim_nominal[idx] = val;
    endtask

    // All five timings, plus one write to an unused index that must change
    // nothing.
    task automatic write_windows(input logic [TICK_W-1:0] lead_mark,
                                 input logic [TICK_W-1:0] lead_space,
                                 input logic [TICK_W-1:0] bit_mark,
                                 input logic [TICK_W-1:0] one_space,
                                 input logic [TICK_W-1:0] zero_space);
        write_reg(REG_ZERO_SPACE, zero_space);
        write_reg(CFG_IDX_W'($urandom_range(NUM_REGS, (1 << CFG_IDX_W) - 1)),
                  TICK_W'($urandom_range(0, TICK_MAX)));
        write_reg(REG_LEAD_MARK, lead_mark);
        write_reg(REG_ONE_SPACE, one_space);
        write_reg(REG_LEAD_SPACE, lead_space);
        write_reg(REG_BIT_MARK, bit_mark);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        stim_nominal[REG_LEAD_MARK]  = RST_LEAD_MARK;
        stim_nominal[REG_LEAD_SPACE] = RST_LEAD_SPACE;
        stim_nominal[REG_BIT_MARK]   = RST_BIT_MARK;
        stim_nominal[REG_ONE_SPACE]  = RST_ONE_SPACE;
        stim_nominal[REG_ZERO_SPACE] = RST_ZERO_SPACE;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Lone durations at both ends of the range, each closing a frame that
        // is far too short.
        send_pulse('0, 1'b1);
        send_pulse(TICK_W'(TICK_MAX), 1'b1);
        // A lead mark on the lower bound and a lead space on the upper bound
        // of their closed windows, then a one space sitting exactly on the
        // excluded lower bound of its open window.
        send_pulse(TICK_W'(RST_LEAD_MARK - RST_LEAD_MARK / TOL_DIV), 1'b0);
        send_pulse(TICK_W'(RST_LEAD_SPACE + RST_LEAD_SPACE / TOL_DIV), 1'b0);
        send_pulse(TICK_W'(TICK_MAX), 1'b0);
        send_pulse(TICK_W'(RST_ONE_SPACE - RST_ONE_SPACE / TOL_DIV), 1'b1);
        // Lead mark one tick past its upper bound, lead space one tick below
        // its lower bound.
        send_pulse(TICK_W'(RST_LEAD_MARK + RST_LEAD_MARK / TOL_DIV + 1), 1'b0);
        send_pulse(TICK_W'(RST_LEAD_SPACE - RST_LEAD_SPACE / TOL_DIV - 1), 1'b1);
        // One complete, clean frame under the reset timings.
        send_frame(FRAME_LEN, NO_FAULT);

        // Phase one: reset timings.
        run_traffic();

        // Phase two: random but plausible timings.
        write_windows(TICK_W'($urandom_range(2000, 20000)), TICK_W'($urandom_range(1000, 10000)),
                      TICK_W'($urandom_range(100, 1000)), TICK_W'($urandom_range(1200, 3000)),
                      TICK_W'($urandom_range(100, 1000)));
        run_traffic();

        // Phase three: timings at the ends of the range. The lead space window
        // shrinks to zero alone, the upper windows get clipped at the top of
        // the tick range, and the zero space window holds a single value.
        write_windows(TICK_W'(TICK_MAX), '0, TICK_W'(TICK_MAX), TICK_W'(TICK_MAX),
                      TICK_W'(4));
        run_traffic();

        // Phase four: the one and zero space windows coincide, so every space
        // that fits decodes as a one.
        begin
            logic [TICK_W-1:0] space_nom;
            space_nom = TICK_W'($urandom_range(500, 3000));
            write_windows('0, TICK_W'(TICK_MAX), TICK_W'($urandom_range(100, 1000)),
                          space_nom, space_nom);
        end
        run_traffic();

        // Phase five: reset timings again, with both sides running flat out.
        idle_enable <= 1'b0;
        write_windows(TICK_W'(RST_LEAD_MARK), TICK_W'(RST_LEAD_SPACE), TICK_W'(RST_BIT_MARK),
                      TICK_W'(RST_ONE_SPACE), TICK_W'(RST_ZERO_SPACE));
        run_traffic();

        if (fail_count == 0) begin
            $display("ir_pulse_distance_decoder: match");
        end else begin
            $display("ir_pulse_distance_decoder: mismatch");
        end
        $finish;
    end

    // A run that is still going at this point has hung.
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("%0t: timeout after %0d cycles", $time, cycle_count);
        $display("ir_pulse_distance_decoder: mismatch");
        $finish;
    end

endmodule

/* ir_pulse_distance_decoder.f */
hdl/irpd_pkg.sv
hdl/irpd_cfg.sv
hdl/ir_pulse_distance_decoder.sv
tb/irpd_frame_checker.sv
tb/tb_top.sv
